[rtl/deq_pkg.sv]
// Package with the action and status codes of the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;

	localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_DUMP       = 3'd4;

	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

	typedef logic [STATUS_W-1:0] status_t;

endpackage

[rtl/deq_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/double_ended_queue_core.sv]
// Double-ended queue kept as a ring buffer in one synchronous RAM.
// Push and pop requests give their status in the cycle after acceptance, one request a cycle
// unless the output stalls. A dump first reads the front word, then streams one word a cycle
// unless the output stalls, front to back; no new request is taken until the last word is in
// the output register. Reset clears the entry count and the front index, not the store.
`timescale 1ns / 1ps

module double_ended_queue_core #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [deq_pkg::ACTION_W-1:0]  action,
	input  logic signed [31:0]            push_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [deq_pkg::STATUS_W-1:0]  status,
	output logic signed [31:0]            dump_value,
	output logic                          last
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	logic             state_q;
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] dslot_q;
	logic [CNT_W-1:0] rem_q;
	logic             out_valid_q;

	deq_pkg::status_t status_q;
	logic [31:0]      dump_value_q;
	logic             last_q;

	logic                  in_acc;
	logic                  out_free;
	logic                  full;
	logic                  empty;
	logic [IDX_W-1:0]      front_prev;
	logic [IDX_W-1:0]      front_next;
	logic [IDX_W-1:0]      dslot_next;
	logic [CNT_W:0]        back_sum;
	logic [IDX_W-1:0]      back_slot;
	logic [63:0]           push_wide;
	logic [63:0]           rd_wide;

	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;

	logic                  load_out;
	deq_pkg::status_t      nxt_status;
	logic [31:0]           nxt_value;
	logic                  nxt_last;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	assign front_prev = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_next = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign dslot_next = (dslot_q == IDX_W'(DEPTH - 1)) ? '0 : dslot_q + 1'b1;

	// Front plus count stays below twice the depth, so one subtract wraps it.
	assign back_sum  = {{(CNT_W + 1 - IDX_W){1'b0}}, front_q} + {1'b0, count_q};
	assign back_slot = (back_sum >= (CNT_W + 1)'(DEPTH)) ?
		IDX_W'(back_sum - (CNT_W + 1)'(DEPTH)) : IDX_W'(back_sum);

	assign push_wide = {{32{push_value[31]}}, push_value};

	always_comb begin
		rd_wide = {64{rd_data[DATA_WIDTH-1]}};
		rd_wide[DATA_WIDTH-1:0] = rd_data;
	end

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = front_prev;
		rd_en      = 1'b0;
		rd_addr    = front_q;
		load_out   = 1'b0;
		nxt_status = deq_pkg::STS_OK;
		nxt_value  = '0;
		nxt_last   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (action) inside
						deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
							load_out = 1'b1;
							if (full) begin
								nxt_status = deq_pkg::STS_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = (action == deq_pkg::ACT_PUSH_FRONT) ?
									front_prev : back_slot;
							end
						end
						deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK: begin
							load_out = 1'b1;
							if (empty) begin
								nxt_status = deq_pkg::STS_EMPTY;
							end
						end
						deq_pkg::ACT_DUMP: begin
							if (empty) begin
								load_out   = 1'b1;
								nxt_status = deq_pkg::STS_EMPTY;
							end else begin
								rd_en = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_DUMP: begin
				rd_addr = dslot_next;
				if (out_free) begin
					load_out  = 1'b1;
					nxt_value = rd_wide[31:0];
					nxt_last  = (rem_q == '0);
					rd_en     = (rem_q != '0);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			dslot_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= load_out;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (action)
							deq_pkg::ACT_PUSH_FRONT: begin
								if (!full) begin
									front_q <= front_prev;
									count_q <= count_q + 1'b1;
								end
							end
							deq_pkg::ACT_PUSH_BACK: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
							end
							deq_pkg::ACT_POP_FRONT: begin
								if (!empty) begin
									front_q <= front_next;
									count_q <= count_q - 1'b1;
								end
							end
							deq_pkg::ACT_POP_BACK: begin
								if (!empty) begin
									count_q <= count_q - 1'b1;
								end
							end
							deq_pkg::ACT_DUMP: begin
								if (!empty) begin
									state_q <= ST_DUMP;
									dslot_q <= front_q;
									rem_q   <= count_q - 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DUMP: begin
					if (out_free) begin
						if (rem_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							dslot_q <= dslot_next;
							rem_q   <= rem_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q     <= nxt_status;
			dump_value_q <= nxt_value;
			last_q       <= nxt_last;
		end
	end

	deq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(push_wide[DATA_WIDTH-1:0]),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign dump_value = dump_value_q;
	assign last       = last_q;

endmodule
